// ===== rtl/core/ddft_pkg.sv =====
// Shared types, widths, constants and twiddle helpers for the direct DFT core.
`default_nettype none

package ddft_pkg;

   localparam int DDFT_POINTS      = 64;
   localparam int DDFT_SAMPLE_BITS = 16;

   localparam int IN_W       = 16;
   localparam int OUT_W      = 24;
   localparam int BIN_W      = 6;
   localparam int TW_W       = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * OUT_W - BIN_W;
   localparam int RND_SHIFT  = 15;

   localparam longint OUT_MAX = 64'sd8388607;
   localparam longint OUT_MIN = -64'sd8388608;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Taylor term divisors for sine and cosine, one per series step
   localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};
   localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   // Round a non-negative Q2.30 value to Q1.15 and saturate at the top.
   function automatic logic signed [TW_W-1:0] to_q15(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v < 0) ? 64'sd0 : v;
      r = (r + 64'sd16384) >>> RND_SHIFT;
      if (r > 64'sd32767) begin
         r = 64'sd32767;
      end
      return TW_W'(r);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/direct_dft_core.sv =====
// Direct N-point DFT core: sample store, twiddle table and one complex MAC.
//
// Load POINTS complex samples, one item per cycle, on the req_ stream. Once the
// last sample of a frame is stored the core stops taking items and computes
// every bin X[k] = sum x[n]*exp(-j*2*pi*k*n/POINTS) by reading the sample
// store once per term and feeding one complex multiply-accumulate. Each bin
// runs POINTS store reads, then drains through four pipeline stages, then
// hands the bin to the output register; back-pressure on rsp_ stretches the
// handoff.
// Bins leave in order of k, the final bin with rsp_tlast set. The core
// takes the first sample of the next frame while the final bin still waits
// in the output register. The sample store needs no clearing after reset.
`default_nettype none

module direct_dft_core #(
   parameter int POINTS      = ddft_pkg::DDFT_POINTS,
   parameter int SAMPLE_BITS = ddft_pkg::DDFT_SAMPLE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: sample_re [15:0], sample_im [31:16]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ddft_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: bin_index [5:0], bin_re [29:6], bin_im [53:30], zero pad
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [ddft_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import ddft_pkg::*;

   localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int SW     = (SAMPLE_BITS > IN_W) ? IN_W + 1 : SAMPLE_BITS;
   localparam int PROD_W = SW + TW_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int TERM_W = SW + 2;
   localparam int ACC_W  = TERM_W + IDX_W;
   localparam int SAT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

   localparam logic [IDX_W-1:0]        LAST_IDX   = IDX_W'(POINTS - 1);
   localparam logic [IDX_W:0]          POINTS_EXT = (IDX_W + 1)'(POINTS);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(16384);
   localparam logic signed [SAT_W-1:0] SAT_HI     = SAT_W'(OUT_MAX);
   localparam logic signed [SAT_W-1:0] SAT_LO     = SAT_W'(OUT_MIN);

   // Twiddle entry m: cos or sin of 2*pi*m/POINTS in Q1.15, built at elaboration
   function automatic logic signed [TW_W-1:0] tw_entry(input int m, input logic want_sin);
      int                     q4;
      int                     quad;
      int                     r;
      logic                   swap;
      logic [63:0]            rr;
      logic [63:0]            x;
      logic [63:0]            x2;
      logic [63:0]            ts;
      logic [63:0]            tc;
      logic signed [63:0]     ss;
      logic signed [63:0]     cs;
      logic signed [TW_W-1:0] cq;
      logic signed [TW_W-1:0] sq;
      logic signed [TW_W-1:0] c;
      logic signed [TW_W-1:0] s;
      logic signed [TW_W-1:0] vc;
      logic signed [TW_W-1:0] vs;
      q4   = 4 * m;
      quad = q4 / POINTS;
      r    = q4 - quad * POINTS;
      swap = (2 * r > POINTS);
      rr   = swap ? 64'(POINTS - r) : 64'(r);
      x    = (rr * HALF_PI_Q30) / POINTS;
      x2   = (x * x) >> 30;
      ts   = x;
      tc   = ONE_Q30;
      ss   = signed'(x);
      cs   = signed'(ONE_Q30);
      for (int i = 0; i < 7; i++) begin
         ts = ((ts * x2) >> 30) / SIN_DIV[i];
         tc = ((tc * x2) >> 30) / COS_DIV[i];
         if ((i % 2) == 0) begin
            ss = ss - signed'(ts);
            cs = cs - signed'(tc);
         end else begin
            ss = ss + signed'(ts);
            cs = cs + signed'(tc);
         end
      end
      cq = to_q15(cs);
      sq = to_q15(ss);
      c  = swap ? sq : cq;
      s  = swap ? cq : sq;
      unique case (quad % 4)
         0: begin vc = c;  vs = s;  end
         1: begin vc = -s; vs = c;  end
         2: begin vc = -c; vs = -s; end
         default: begin vc = s; vs = -c; end
      endcase
      return want_sin ? vs : vc;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      priority if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return OUT_W'(r);
   endfunction

   // Constant twiddle table
   logic signed [TW_W-1:0] cos_tab [POINTS];
   logic signed [TW_W-1:0] sin_tab [POINTS];

   for (genvar m = 0; m < POINTS; m++) begin : g_tw
      localparam logic signed [TW_W-1:0] COS_V = tw_entry(m, 1'b0);
      localparam logic signed [TW_W-1:0] SIN_V = tw_entry(m, 1'b1);
      assign cos_tab[m] = COS_V;
      assign sin_tab[m] = SIN_V;
   end

   // Take the low SAMPLE_BITS of each input; wider settings take IN_W bits as non-negative
   logic [SW-1:0] in_re;
   logic [SW-1:0] in_im;

   if (SAMPLE_BITS > IN_W) begin : g_wide
      assign in_re = {1'b0, req_tdata[IN_W-1:0]};
      assign in_im = {1'b0, req_tdata[2*IN_W-1:IN_W]};
   end else begin : g_narrow
      assign in_re = req_tdata[SAMPLE_BITS-1:0];
      assign in_im = req_tdata[IN_W+SAMPLE_BITS-1:IN_W];
   end

   // Sequencer state
   state_type      state_ff,    state_in;
   logic [IDX_W-1:0] load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0] n_ff,        n_in;
   logic [IDX_W-1:0] k_ff,        k_in;
   logic [IDX_W-1:0] idx_ff,      idx_in;
   logic [IDX_W:0]   idx_sum;

   logic req_fire;
   logic out_free;
   logic out_load;

   // Pipeline control
   logic s1_vld_ff, s1_first_ff, s1_last_ff;
   logic s2_vld_ff, s2_first_ff, s2_last_ff;
   logic s3_vld_ff, s3_first_ff, s3_last_ff;
   logic done_ff;

   // Memory and pipeline payload
   logic [2*SW-1:0]          store_mem [POINTS];
   logic [2*SW-1:0]          rd_ff;
   logic signed [TW_W-1:0]   cos_ff;
   logic signed [TW_W-1:0]   sin_ff;
   logic signed [SW-1:0]     x_re;
   logic signed [SW-1:0]     x_im;
   logic signed [PROD_W-1:0] p_rc_ff, p_is_ff, p_ic_ff, p_rs_ff;
   logic signed [SUM_W-1:0]  sum_re, sum_im;
   logic signed [TERM_W-1:0] term_re_ff, term_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;

   // Output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic signed [OUT_W-1:0] bin_re;
   logic signed [OUT_W-1:0] bin_im;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign out_load   = (state_ff == ST_OUT) && out_free;

   assign idx_sum = {1'b0, idx_ff} + {1'b0, k_ff};

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      idx_in      = idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (load_cnt_ff == LAST_IDX) begin
                  // frame complete: start bin zero
                  load_cnt_in = '0;
                  state_in    = ST_RUN;
                  n_in        = '0;
                  k_in        = '0;
                  idx_in      = '0;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_RUN: begin
            // step n and the twiddle index (k*n) mod POINTS
            idx_in = (idx_sum >= POINTS_EXT) ? IDX_W'(idx_sum - POINTS_EXT)
                                             : IDX_W'(idx_sum);
            if (n_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (done_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               n_in   = '0;
               idx_in = '0;
               if (k_ff == LAST_IDX) begin
                  k_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         idx_ff      <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         idx_ff      <= idx_in;
         s1_vld_ff   <= (state_ff == ST_RUN);
         s2_vld_ff   <= s1_vld_ff;
         s3_vld_ff   <= s2_vld_ff;
         done_ff     <= s3_vld_ff && s3_last_ff;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Sample store: written only while loading, read data used only while running,
   // so accesses never overlap and no forwarding is needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         store_mem[load_cnt_ff] <= {in_im, in_re};
      end
      rd_ff <= store_mem[n_ff];
   end

   // Stage 1: store read data and twiddle pair
   always_ff @(posedge clock) begin
      cos_ff      <= cos_tab[idx_ff];
      sin_ff      <= sin_tab[idx_ff];
      s1_first_ff <= (n_ff == '0);
      s1_last_ff  <= (n_ff == LAST_IDX);
   end

   assign x_re = rd_ff[SW-1:0];
   assign x_im = rd_ff[2*SW-1:SW];

   // Stage 2: four partial products
   always_ff @(posedge clock) begin
      p_rc_ff     <= x_re * cos_ff;
      p_is_ff     <= x_im * sin_ff;
      p_ic_ff     <= x_im * cos_ff;
      p_rs_ff     <= x_re * sin_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
   end

   // Stage 3: combine and round toward minus infinity after adding half
   assign sum_re = SUM_W'(p_rc_ff) + SUM_W'(p_is_ff) + ROUND_HALF;
   assign sum_im = SUM_W'(p_ic_ff) - SUM_W'(p_rs_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      term_re_ff  <= TERM_W'(sum_re >>> RND_SHIFT);
      term_im_ff  <= TERM_W'(sum_im >>> RND_SHIFT);
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
   end

   // Stage 4: accumulate, restarting on the first term of each bin
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (s3_vld_ff) begin
         acc_re_in = (s3_first_ff ? ACC_W'(0) : acc_re_ff) + ACC_W'(term_re_ff);
         acc_im_in = (s3_first_ff ? ACC_W'(0) : acc_im_ff) + ACC_W'(term_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   // Output register: hold until taken, load the finished bin when free
   assign bin_re = sat_out(SAT_W'(acc_re_ff));
   assign bin_im = sat_out(SAT_W'(acc_im_ff));

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {RSP_PAD_W'(0), bin_im, bin_re, BIN_W'(k_ff)};
         rsp_last_ff <= (k_ff == LAST_IDX);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ddft_checker.sv =====
// Port-level checker for the direct DFT core, bound to the direct_dft_core module.
`default_nettype none

module ddft_checker #(
   parameter int POINTS = ddft_pkg::DDFT_POINTS
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ddft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);
   import ddft_pkg::*;

   localparam logic [6:0]       LAST_IN  = 7'(POINTS - 1);
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(POINTS - 1);

   logic [6:0]       in_cnt_ff, in_cnt_in;
   logic [BIN_W-1:0] exp_bin_ff, exp_bin_in;
   // frames completed whose final bin has not been taken yet (at most two)
   logic [1:0]       pend_ff, pend_in;
   logic             in_fire, out_fire, frame_done, last_fire, last_wait, busy_now;

   assign in_fire    = req_tvalid && req_tready;
   assign out_fire   = rsp_tvalid && rsp_tready;
   assign frame_done = in_fire && (in_cnt_ff == LAST_IN);
   assign last_fire  = out_fire && rsp_tlast;
   assign last_wait  = rsp_tvalid && rsp_tlast;
   // the core computes whenever a pending frame has not yet reached the output register
   assign busy_now   = (pend_ff > {1'b0, last_wait});

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      exp_bin_in = exp_bin_ff;
      pend_in    = pend_ff;
      if (in_fire) begin
         in_cnt_in = frame_done ? 7'd0 : in_cnt_ff + 7'd1;
      end
      if (out_fire) begin
         exp_bin_in = rsp_tlast ? '0 : exp_bin_ff + 1'b1;
      end
      priority if (frame_done && !last_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (!frame_done && last_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         exp_bin_ff <= '0;
         pend_ff    <= '0;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         exp_bin_ff <= exp_bin_in;
         pend_ff    <= pend_in;
      end
   end

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Bins leave in order of k
   a_bin_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[BIN_W-1:0] == exp_bin_ff)
      else $error("bin index out of order");

   // Last marker sits on the final bin only
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[BIN_W-1:0] == LAST_BIN))
      else $error("last marker on wrong bin");

   // No sample taken while the frame's bins are still being computed
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_now |-> !req_tready)
      else $error("sample accepted during compute");

   // Results appear only after a full frame
   a_rsp_after_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> pend_ff != 2'd0)
      else $error("result item without a complete frame");

endmodule

bind direct_dft_core ddft_checker #(.POINTS(POINTS)) u_ddft_checker (.*);

`default_nettype wire
